// ===== hdl/wpst_pkg.sv =====
// Shared types, constants and helper functions for the windowed PID
// steering and throttle controller. No dependencies.
`timescale 1ns / 1ps

package wpst_pkg;

  localparam int unsigned HIST_DEPTH = 10;
  localparam int unsigned SLOT_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(HIST_DEPTH + 1);

  localparam int unsigned SUM_W = 40;
  localparam int unsigned MAG_W = 52;
  localparam int unsigned GAIN_W = 32;
  localparam int unsigned PROD_W = MAG_W + GAIN_W;
  localparam int unsigned DVS_W = 20;
  localparam int unsigned MUL_STEPS = GAIN_W;
  localparam int unsigned DIV_STEPS = MAG_W;
  localparam int unsigned STEP_W = $clog2(MAG_W + 1);

  localparam int unsigned ONE_SECOND_US = 1000000;
  localparam int unsigned DERIV_MIN_US = 10;
  localparam int unsigned ONE_Q16 = 65536;
  localparam int unsigned TWO_OVER_PI_Q31 = 1367130551;

  localparam int unsigned CFG_W = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_STEER_KP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_KD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_KI = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_KP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THR_KD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THR_KI = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 3'd7;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef enum logic [1:0] {
    SH_0,
    SH_20,
    SH_31
  } shift_sel_e;

  typedef struct packed {
    logic              start;
    alu_op_e           op;
    shift_sel_e        sh;
    logic [MAG_W-1:0]  a;
    logic [GAIN_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] mag;
  } alu_rsp_t;

  typedef struct packed {
    logic               advance;
    logic               add;
    logic signed [15:0] e;
    logic signed [16:0] serr;
  } hist_cmd_t;

  // Clamp to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [MAG_W-1:0] x);
    logic fits;
    fits = (x[MAG_W-1:31] == '0) || (x[MAG_W-1:31] == '1);
    if (fits) begin
      return x[31:0];
    end
    return x[MAG_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  function automatic logic [MAG_W-1:0] abs_mag(input logic signed [MAG_W-1:0] x);
    return x[MAG_W-1] ? (~x + MAG_W'(1)) : x;
  endfunction

  function automatic logic [GAIN_W-1:0] gain_mag(input logic [GAIN_W-1:0] g);
    return g[GAIN_W-1] ? (~g + GAIN_W'(1)) : g;
  endfunction

endpackage

// ===== hdl/wpst_if.sv =====
// Valid/ready channel interfaces for sample requests and command results.
// Depends on wpst_pkg.
`timescale 1ns / 1ps

interface wpst_in_if import wpst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [15:0] cross_track_error;
  logic        [15:0] speed;
  logic        [19:0] elapsed_us;

  modport source(output valid, cross_track_error, speed, elapsed_us, input ready);
  modport sink(input valid, cross_track_error, speed, elapsed_us, output ready);
endinterface

interface wpst_out_if import wpst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] steering;
  logic signed [31:0] throttle;

  modport source(output valid, steering, throttle, input ready);
  modport sink(input valid, steering, throttle, output ready);
endinterface

// ===== hdl/windowed_pid_steer_throttle.sv =====
// Top level: configuration registers, step sequencer and output register.
// Depends on wpst_pkg, wpst_if, wpst_alu and wpst_hist.
//
//   channel   dir  handshake          payload
//   in_if     in   valid/ready        cross_track_error, speed, elapsed_us
//   out_if    out  valid/ready        steering, throttle
//   cfg       in   cfg_we_i (no wait) cfg_idx_i, cfg_wdata_i
//
// After the accepting edge a sample passes through the bucket advance and add
// states, then multiplies and divides in the shared iterative unit, and a
// final state that loads the result: five multiplies without the derivative
// and four more multiplies and two divides with it. The load waits while a
// previous result is still held; in_if.ready rises again in idle.
// Reset is asynchronous; it loads default gains and speeds into the
// configuration registers and clears the rest of the state; in_if.ready stays
// low while a sample is in work, and a finished result waits in the output register while the next sample is taken.
`timescale 1ns / 1ps

module windowed_pid_steer_throttle import wpst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  wpst_in_if.sink              in_if,
  wpst_out_if.source           out_if,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ADV, ST_ADD, ST_KP, ST_KI, ST_TKP, ST_TKI,
    ST_D1, ST_D2, ST_D3, ST_TD1, ST_TD2, ST_TD3, ST_SCALE, ST_OUT
  } state_e;

  // configuration
  logic [GAIN_W-1:0] kp_q, kd_q, ki_q, tkp_q, tkd_q, tki_q;
  logic [15:0]       target_q, min_speed_q;

  // sequencer
  state_e                  state_q;
  logic                    issued_q;
  logic                    started_q;
  logic [19:0]             bkt_elapsed_q;
  logic signed [15:0]      prev_e_q;
  logic signed [15:0]      e_q;
  logic signed [16:0]      serr_q;
  logic signed [16:0]      de_q;
  logic [15:0]             spd_q;
  logic [19:0]             dt_q;
  logic                    new_bkt_q;
  logic                    deriv_q;
  logic signed [MAG_W-1:0] acc_s_q, acc_t_q, tmp_q;
  logic signed [31:0]      steer_res_q;
  logic                    out_valid_q;
  logic signed [31:0]      steering_q, throttle_q;

  logic [19:0]             dt_eff;
  logic [20:0]             t_sum;
  logic                    new_bkt;
  logic                    op_neg;
  logic                    is_op;
  alu_req_t                alu_req;
  alu_rsp_t                alu_rsp;
  hist_cmd_t               hist_cmd;
  logic signed [SUM_W-1:0] steer_sum, speed_sum;
  logic signed [MAG_W-1:0] mag_s, op_res;
  logic signed [31:0]      thr_sat, thr_final;

  wpst_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  wpst_hist u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (hist_cmd),
    .steer_sum_o (steer_sum),
    .speed_sum_o (speed_sum)
  );

  assign in_if.ready     = (state_q == ST_IDLE);
  assign out_if.valid    = out_valid_q;
  assign out_if.steering = steering_q;
  assign out_if.throttle = throttle_q;

  // the first sample counts as zero elapsed time
  assign dt_eff  = started_q ? in_if.elapsed_us : '0;
  assign t_sum   = {1'b0, bkt_elapsed_q} + {1'b0, dt_eff};
  assign new_bkt = t_sum >= 21'(ONE_SECOND_US);

  assign hist_cmd.advance = (state_q == ST_ADV) && new_bkt_q;
  assign hist_cmd.add     = (state_q == ST_ADD);
  assign hist_cmd.e       = e_q;
  assign hist_cmd.serr    = serr_q;

  assign is_op = (state_q != ST_IDLE) && (state_q != ST_ADV) &&
                 (state_q != ST_ADD) && (state_q != ST_OUT);

  always_comb begin
    alu_req.start = is_op && !issued_q;
    alu_req.op    = ALU_MUL;
    alu_req.sh    = SH_20;
    alu_req.a     = '0;
    alu_req.b     = '0;
    op_neg        = 1'b0;
    unique case (state_q)
      ST_KP: begin
        alu_req.a = abs_mag(MAG_W'(e_q));
        alu_req.b = gain_mag(kp_q);
        op_neg    = e_q[15] ^ kp_q[GAIN_W-1];
      end
      ST_KI: begin
        alu_req.a = abs_mag(MAG_W'(steer_sum));
        alu_req.b = gain_mag(ki_q);
        op_neg    = steer_sum[SUM_W-1] ^ ki_q[GAIN_W-1];
      end
      ST_TKP: begin
        alu_req.a = abs_mag(MAG_W'(e_q));
        alu_req.b = gain_mag(tkp_q);
        op_neg    = tkp_q[GAIN_W-1];
      end
      ST_TKI: begin
        alu_req.a = abs_mag(MAG_W'(speed_sum));
        alu_req.b = gain_mag(tki_q);
        op_neg    = speed_sum[SUM_W-1] ^ tki_q[GAIN_W-1];
      end
      ST_D1: begin
        alu_req.sh = SH_0;
        alu_req.a  = abs_mag(MAG_W'(de_q));
        alu_req.b  = gain_mag(kd_q);
        op_neg     = de_q[16] ^ kd_q[GAIN_W-1];
      end
      ST_TD1: begin
        alu_req.sh = SH_0;
        alu_req.a  = abs_mag(MAG_W'(de_q));
        alu_req.b  = gain_mag(tkd_q);
        op_neg     = de_q[16] ^ tkd_q[GAIN_W-1];
      end
      ST_D2, ST_TD2: begin
        alu_req.a = abs_mag(tmp_q);
        alu_req.b = GAIN_W'(ONE_SECOND_US);
        op_neg    = tmp_q[MAG_W-1];
      end
      ST_D3, ST_TD3: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = abs_mag(tmp_q);
        alu_req.b  = GAIN_W'(dt_q);
        op_neg     = tmp_q[MAG_W-1];
      end
      ST_SCALE: begin
        alu_req.sh = SH_31;
        alu_req.a  = abs_mag(acc_s_q);
        alu_req.b  = GAIN_W'(TWO_OVER_PI_Q31);
        op_neg     = acc_s_q[MAG_W-1];
      end
      default: begin
        alu_req.start = 1'b0;
      end
    endcase
  end

  assign mag_s  = $signed(alu_rsp.mag);
  assign op_res = op_neg ? -mag_s : mag_s;

  assign thr_sat   = sat32(acc_t_q);
  assign thr_final = ((spd_q < min_speed_q) && (thr_sat < 32'sd65536)) ?
                     32'(ONE_Q16) : thr_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q          <= 32'd53687091;
      kd_q          <= 32'd16106127;
      ki_q          <= 32'd18790;
      tkp_q         <= 32'd5368709;
      tkd_q         <= 32'd107374182;
      tki_q         <= 32'd5369;
      target_q      <= 16'd25600;
      min_speed_q   <= 16'd2560;
      state_q       <= ST_IDLE;
      issued_q      <= 1'b0;
      started_q     <= 1'b0;
      bkt_elapsed_q <= '0;
      prev_e_q      <= '0;
      e_q           <= '0;
      serr_q        <= '0;
      de_q          <= '0;
      spd_q         <= '0;
      dt_q          <= '0;
      new_bkt_q     <= 1'b0;
      deriv_q       <= 1'b0;
      acc_s_q       <= '0;
      acc_t_q       <= '0;
      tmp_q         <= '0;
      steer_res_q   <= '0;
      out_valid_q   <= 1'b0;
      steering_q    <= '0;
      throttle_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_STEER_KP:     kp_q        <= cfg_wdata_i;
          REG_STEER_KD:     kd_q        <= cfg_wdata_i;
          REG_STEER_KI:     ki_q        <= cfg_wdata_i;
          REG_THR_KP:       tkp_q       <= cfg_wdata_i;
          REG_THR_KD:       tkd_q       <= cfg_wdata_i;
          REG_THR_KI:       tki_q       <= cfg_wdata_i;
          REG_TARGET_SPEED: target_q    <= cfg_wdata_i[15:0];
          REG_MIN_SPEED:    min_speed_q <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end

      // in ST_OUT the load below decides the valid flag
      if (out_valid_q && out_if.ready && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_if.valid) begin
            e_q           <= in_if.cross_track_error;
            serr_q        <= $signed({1'b0, in_if.speed}) - $signed({1'b0, target_q});
            de_q          <= started_q ?
                             (17'(in_if.cross_track_error) - 17'(prev_e_q)) : '0;
            prev_e_q      <= in_if.cross_track_error;
            spd_q         <= in_if.speed;
            dt_q          <= dt_eff;
            deriv_q       <= dt_eff > 20'(DERIV_MIN_US);
            new_bkt_q     <= new_bkt;
            bkt_elapsed_q <= new_bkt ? '0 : t_sum[19:0];
            started_q     <= 1'b1;
            state_q       <= ST_ADV;
          end
        end
        ST_ADV: state_q <= ST_ADD;
        ST_ADD: begin
          issued_q <= 1'b0;
          state_q  <= ST_KP;
        end
        ST_OUT: begin
          // hold until the previous result is taken
          if (!out_valid_q || out_if.ready) begin
            steering_q  <= steer_res_q;
            throttle_q  <= thr_final;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          if (!issued_q) begin
            issued_q <= 1'b1;
          end else if (alu_rsp.done) begin
            issued_q <= 1'b0;
            unique case (state_q)
              ST_KP: begin
                acc_s_q <= -op_res;
                state_q <= ST_KI;
              end
              ST_KI: begin
                acc_s_q <= acc_s_q - op_res;
                state_q <= ST_TKP;
              end
              ST_TKP: begin
                acc_t_q <= MAG_W'(ONE_Q16) - op_res;
                state_q <= ST_TKI;
              end
              ST_TKI: begin
                acc_t_q <= acc_t_q - op_res;
                state_q <= deriv_q ? ST_D1 : ST_SCALE;
              end
              ST_D1: begin
                tmp_q   <= op_res;
                state_q <= ST_D2;
              end
              ST_D2: begin
                tmp_q   <= op_res;
                state_q <= ST_D3;
              end
              ST_D3: begin
                acc_s_q <= acc_s_q - op_res;
                state_q <= ST_TD1;
              end
              ST_TD1: begin
                tmp_q   <= op_res;
                state_q <= ST_TD2;
              end
              ST_TD2: begin
                tmp_q   <= op_res;
                state_q <= ST_TD3;
              end
              ST_TD3: begin
                acc_t_q <= acc_t_q - op_res;
                state_q <= ST_SCALE;
              end
              ST_SCALE: begin
                steer_res_q <= sat32(op_res);
                state_q     <= ST_OUT;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
      endcase
    end
  end

endmodule

// ===== hdl/wpst_alu.sv =====
// Shared iterative unit: shift-add magnitude multiply with a selectable
// right shift, and restoring magnitude divide. Depends on wpst_pkg.
`timescale 1ns / 1ps

module wpst_alu import wpst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic              busy_q;
  logic              done_q;
  alu_op_e           op_q;
  shift_sel_e        sh_q;
  logic [STEP_W-1:0] cnt_q;
  logic [PROD_W-1:0] prod_q;
  logic [MAG_W-1:0]  a_q;
  logic [GAIN_W-1:0] b_q;
  logic [DVS_W:0]    rem_q;
  logic [MAG_W-1:0]  quo_q;

  logic [DVS_W:0]    rem_sh;
  logic              fits;
  logic [MAG_W-1:0]  mul_res;

  assign rem_sh = {rem_q[DVS_W-1:0], quo_q[MAG_W-1]};
  assign fits   = rem_sh >= {1'b0, b_q[DVS_W-1:0]};

  always_comb begin
    unique case (sh_q)
      SH_0:    mul_res = prod_q[MAG_W-1:0];
      SH_20:   mul_res = prod_q[20 +: MAG_W];
      SH_31:   mul_res = prod_q[31 +: MAG_W];
      default: mul_res = prod_q[MAG_W-1:0];
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.mag  = (op_q == ALU_DIV) ? quo_q : mul_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= ALU_MUL;
      sh_q   <= SH_0;
      cnt_q  <= '0;
      prod_q <= '0;
      a_q    <= '0;
      b_q    <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        sh_q   <= req_i.sh;
        a_q    <= req_i.a;
        b_q    <= req_i.b;
        prod_q <= '0;
        rem_q  <= '0;
        quo_q  <= req_i.a;
        cnt_q  <= (req_i.op == ALU_MUL) ? STEP_W'(MUL_STEPS) : STEP_W'(DIV_STEPS);
      end else if (busy_q) begin
        if (op_q == ALU_MUL) begin
          // one multiplier bit per cycle, MSB first
          prod_q <= (prod_q << 1) + (b_q[GAIN_W-1] ? PROD_W'(a_q) : PROD_W'(0));
          b_q    <= b_q << 1;
        end else begin
          rem_q <= fits ? (rem_sh - {1'b0, b_q[DVS_W-1:0]}) : rem_sh;
          quo_q <= {quo_q[MAG_W-2:0], fits};
        end
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/wpst_hist.sv =====
// One-second bucket rings for steering and speed error with running
// window sums. Depends on wpst_pkg.
`timescale 1ns / 1ps

module wpst_hist import wpst_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hist_cmd_t               cmd_i,
  output logic signed [SUM_W-1:0] steer_sum_o,
  output logic signed [SUM_W-1:0] speed_sum_o
);

  logic signed [31:0]      steer_b_q [HIST_DEPTH];
  logic signed [31:0]      speed_b_q [HIST_DEPTH];
  logic signed [SUM_W-1:0] steer_sum_q;
  logic signed [SUM_W-1:0] speed_sum_q;
  logic [SLOT_W-1:0]       slot_q;
  logic [CNT_W-1:0]        count_q;

  logic [SLOT_W-1:0]       slot_nxt;
  logic signed [31:0]      steer_old, speed_old, steer_nv, speed_nv;
  logic signed [32:0]      steer_dlt, speed_dlt;

  assign slot_nxt = (slot_q == SLOT_W'(HIST_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);

  assign steer_old = steer_b_q[slot_q];
  assign speed_old = speed_b_q[slot_q];
  assign steer_nv  = sat32(MAG_W'(33'(steer_old) + 33'(cmd_i.e)));
  assign speed_nv  = sat32(MAG_W'(33'(speed_old) + 33'(cmd_i.serr)));
  assign steer_dlt = 33'(steer_nv) - 33'(steer_old);
  assign speed_dlt = 33'(speed_nv) - 33'(speed_old);

  assign steer_sum_o = steer_sum_q;
  assign speed_sum_o = speed_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        steer_b_q[i] <= '0;
        speed_b_q[i] <= '0;
      end
      steer_sum_q <= '0;
      speed_sum_q <= '0;
      slot_q      <= '0;
      count_q     <= CNT_W'(1);
    end else if (cmd_i.advance) begin
      // reuse the oldest slot once the ring is full
      if (count_q >= CNT_W'(HIST_DEPTH)) begin
        steer_sum_q <= steer_sum_q - SUM_W'(steer_b_q[slot_nxt]);
        speed_sum_q <= speed_sum_q - SUM_W'(speed_b_q[slot_nxt]);
      end else begin
        count_q <= count_q + CNT_W'(1);
      end
      steer_b_q[slot_nxt] <= '0;
      speed_b_q[slot_nxt] <= '0;
      slot_q              <= slot_nxt;
    end else if (cmd_i.add) begin
      steer_b_q[slot_q] <= steer_nv;
      speed_b_q[slot_q] <= speed_nv;
      steer_sum_q       <= steer_sum_q + SUM_W'(steer_dlt);
      speed_sum_q       <= speed_sum_q + SUM_W'(speed_dlt);
    end
  end

endmodule
